### rtl/core/cbl_pkg.sv
// Shared types, constants and helpers of the clipped coverage blend block.
`default_nettype none

package cbl_pkg;

   // Field widths
   localparam int unsigned CoordWidth   = 16;
   localparam int unsigned CovWidth     = 8;
   localparam int unsigned PixelWidth   = 32;
   localparam int unsigned ColorWidth   = 24;
   localparam int unsigned DimWidth     = 14;
   localparam int unsigned AddrWidth    = 26;
   localparam int unsigned EdgeWidth    = CoordWidth + 1;
   localparam int unsigned Channels     = 3;
   localparam int unsigned ChanWidth    = 8;
   localparam int unsigned MixWidth     = 2 * ChanWidth;

   // Stream payload widths
   localparam int unsigned ReqDataWidth = 2 * CoordWidth + CovWidth + PixelWidth;
   localparam int unsigned RspBodyWidth = AddrWidth + PixelWidth;
   localparam int unsigned RspDataWidth = 64;

   // Register file
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [ChanWidth-1:0] AlphaOpaque = 8'hff;
   localparam logic [ChanWidth-1:0] CovFull     = 8'd255;

   typedef enum logic [2:0] {
      REG_TEXT_COLOR    = 3'd0,
      REG_BUFFER_WIDTH  = 3'd1,
      REG_BUFFER_HEIGHT = 3'd2,
      REG_ROW_STRIDE    = 3'd3,
      REG_CLIP_LEFT     = 3'd4,
      REG_CLIP_TOP      = 3'd5,
      REG_CLIP_RIGHT    = 3'd6,
      REG_CLIP_BOTTOM   = 3'd7
   } cbl_reg_type;

   // Configuration as seen by the datapath: clip box already cut to the buffer
   typedef struct packed {
      logic [ColorWidth-1:0]       text_color;
      logic [DimWidth-1:0]         row_stride;
      logic signed [EdgeWidth-1:0] x0;
      logic signed [EdgeWidth-1:0] x1;
      logic signed [EdgeWidth-1:0] y0;
      logic signed [EdgeWidth-1:0] y1;
      logic                        box_ok;
   } cbl_cfg_type;

   // Exact x / 255 for x <= 255*255 via reciprocal with correction
   function automatic logic [ChanWidth-1:0] div255(input logic [MixWidth-1:0] x);
      logic [MixWidth:0] t;
      t = {1'b0, x} + {{MixWidth{1'b0}}, 1'b1} + {{(ChanWidth + 1){1'b0}}, x[MixWidth-1:ChanWidth]};
      return t[MixWidth-1:ChanWidth];
   endfunction

endpackage

`default_nettype wire

### rtl/core/cbl_csr.sv
// Configuration registers with APB-style access and clip box preparation.
`default_nettype none

module cbl_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cbl_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [cbl_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic      [cbl_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                   csr_pready,
   output cbl_pkg::cbl_cfg_type                   cfg
);

   logic [cbl_pkg::ColorWidth-1:0]        text_color_ff;
   logic [cbl_pkg::DimWidth-1:0]          buffer_width_ff;
   logic [cbl_pkg::DimWidth-1:0]          buffer_height_ff;
   logic [cbl_pkg::DimWidth-1:0]          row_stride_ff;
   logic signed [cbl_pkg::CoordWidth-1:0] clip_left_ff;
   logic signed [cbl_pkg::CoordWidth-1:0] clip_top_ff;
   logic signed [cbl_pkg::CoordWidth-1:0] clip_right_ff;
   logic signed [cbl_pkg::CoordWidth-1:0] clip_bottom_ff;

   cbl_pkg::cbl_reg_type reg_sel;
   logic                 wr_en;

   logic signed [cbl_pkg::EdgeWidth-1:0] left_ext, top_ext, right_ext, bottom_ext;
   logic signed [cbl_pkg::EdgeWidth-1:0] width_ext, height_ext;

   assign csr_pready = 1'b1;
   assign reg_sel    = cbl_pkg::cbl_reg_type'(csr_paddr[cbl_pkg::CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff    <= '0;
         buffer_width_ff  <= '0;
         buffer_height_ff <= '0;
         row_stride_ff    <= '0;
         clip_left_ff     <= '0;
         clip_top_ff      <= '0;
         clip_right_ff    <= '0;
         clip_bottom_ff   <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            cbl_pkg::REG_TEXT_COLOR:    text_color_ff    <= csr_pwdata[cbl_pkg::ColorWidth-1:0];
            cbl_pkg::REG_BUFFER_WIDTH:  buffer_width_ff  <= csr_pwdata[cbl_pkg::DimWidth-1:0];
            cbl_pkg::REG_BUFFER_HEIGHT: buffer_height_ff <= csr_pwdata[cbl_pkg::DimWidth-1:0];
            cbl_pkg::REG_ROW_STRIDE:    row_stride_ff    <= csr_pwdata[cbl_pkg::DimWidth-1:0];
            cbl_pkg::REG_CLIP_LEFT:     clip_left_ff     <= csr_pwdata[cbl_pkg::CoordWidth-1:0];
            cbl_pkg::REG_CLIP_TOP:      clip_top_ff      <= csr_pwdata[cbl_pkg::CoordWidth-1:0];
            cbl_pkg::REG_CLIP_RIGHT:    clip_right_ff    <= csr_pwdata[cbl_pkg::CoordWidth-1:0];
            cbl_pkg::REG_CLIP_BOTTOM:   clip_bottom_ff   <= csr_pwdata[cbl_pkg::CoordWidth-1:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         cbl_pkg::REG_TEXT_COLOR:    csr_prdata[cbl_pkg::ColorWidth-1:0] = text_color_ff;
         cbl_pkg::REG_BUFFER_WIDTH:  csr_prdata[cbl_pkg::DimWidth-1:0]   = buffer_width_ff;
         cbl_pkg::REG_BUFFER_HEIGHT: csr_prdata[cbl_pkg::DimWidth-1:0]   = buffer_height_ff;
         cbl_pkg::REG_ROW_STRIDE:    csr_prdata[cbl_pkg::DimWidth-1:0]   = row_stride_ff;
         cbl_pkg::REG_CLIP_LEFT:     csr_prdata[cbl_pkg::CoordWidth-1:0] = clip_left_ff;
         cbl_pkg::REG_CLIP_TOP:      csr_prdata[cbl_pkg::CoordWidth-1:0] = clip_top_ff;
         cbl_pkg::REG_CLIP_RIGHT:    csr_prdata[cbl_pkg::CoordWidth-1:0] = clip_right_ff;
         cbl_pkg::REG_CLIP_BOTTOM:   csr_prdata[cbl_pkg::CoordWidth-1:0] = clip_bottom_ff;
         default: csr_prdata = '0;
      endcase
   end

   // Clip box cut to buffer; user keeps it stable while items are in flight
   assign left_ext   = cbl_pkg::EdgeWidth'(clip_left_ff);
   assign top_ext    = cbl_pkg::EdgeWidth'(clip_top_ff);
   assign right_ext  = cbl_pkg::EdgeWidth'(clip_right_ff);
   assign bottom_ext = cbl_pkg::EdgeWidth'(clip_bottom_ff);
   assign width_ext  = $signed({{(cbl_pkg::EdgeWidth - cbl_pkg::DimWidth){1'b0}},
                                buffer_width_ff});
   assign height_ext = $signed({{(cbl_pkg::EdgeWidth - cbl_pkg::DimWidth){1'b0}},
                                buffer_height_ff});

   always_comb begin
      cfg.text_color = text_color_ff;
      cfg.row_stride = row_stride_ff;
      cfg.x0         = left_ext[cbl_pkg::EdgeWidth-1] ? '0 : left_ext;
      cfg.y0         = top_ext[cbl_pkg::EdgeWidth-1]  ? '0 : top_ext;
      cfg.x1         = (right_ext > width_ext)   ? width_ext  : right_ext;
      cfg.y1         = (bottom_ext > height_ext) ? height_ext : bottom_ext;
      cfg.box_ok     = (cfg.x1 > cfg.x0) && (cfg.y1 > cfg.y0);
   end

endmodule

`default_nettype wire

### rtl/core/cbl_pipe.sv
// Four-stage blend datapath: capture, clip test and multiply, sum, divide.
`default_nettype none

module cbl_pipe (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire cbl_pkg::cbl_cfg_type               cfg,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic [cbl_pkg::ReqDataWidth-1:0]   in_data,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output logic                                    out_we,
   output logic      [cbl_pkg::RspBodyWidth-1:0]   out_data
);

   localparam int unsigned CW  = cbl_pkg::CoordWidth;
   localparam int unsigned ChW = cbl_pkg::ChanWidth;
   localparam int unsigned MxW = cbl_pkg::MixWidth;
   localparam int unsigned AW  = cbl_pkg::AddrWidth;
   localparam int unsigned NCh = cbl_pkg::Channels;

   // Stage valids and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // Stage 1: captured input
   logic signed [CW-1:0]                tx1_ff, ty1_ff;
   logic [cbl_pkg::CovWidth-1:0]        cov1_ff;
   logic [cbl_pkg::PixelWidth-1:0]      dp1_ff;

   // Stage 2: clip decision and products
   logic                                we2_in, we2_ff;
   logic [NCh-1:0][MxW-1:0]             src2_in, src2_ff, dst2_in, dst2_ff;
   logic [AW-1:0]                       row2_in, row2_ff;
   logic [CW-1:0]                       tx2_ff;

   // Stage 3: channel sums and address
   logic                                we3_ff;
   logic [NCh-1:0][MxW-1:0]             sum3_in, sum3_ff;
   logic [AW-1:0]                       addr3_in, addr3_ff;

   // Stage 4: output register
   logic                                we4_ff;
   logic [cbl_pkg::RspBodyWidth-1:0]    data4_in, data4_ff;

   logic signed [cbl_pkg::EdgeWidth-1:0] tx_ext, ty_ext;
   logic [ChW-1:0]                       inv_cov;
   logic [CW+cbl_pkg::DimWidth-1:0]      row_full;

   // A stage moves when it is empty or the next one moves
   assign en4      = ~v4_ff | out_ready;
   assign en3      = ~v3_ff | en4;
   assign en2      = ~v2_ff | en3;
   assign en1      = ~v1_ff | en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (en1) begin
         tx1_ff  <= in_data[CW-1:0];
         ty1_ff  <= in_data[2*CW-1:CW];
         cov1_ff <= in_data[2*CW +: cbl_pkg::CovWidth];
         dp1_ff  <= in_data[2*CW + cbl_pkg::CovWidth +: cbl_pkg::PixelWidth];
      end
   end

   // Stage 2: inside test, channel products, row offset
   assign tx_ext   = cbl_pkg::EdgeWidth'(tx1_ff);
   assign ty_ext   = cbl_pkg::EdgeWidth'(ty1_ff);
   assign inv_cov  = cbl_pkg::CovFull - cov1_ff;
   assign row_full = {{cbl_pkg::DimWidth{1'b0}}, ty1_ff} *
                     {{CW{1'b0}}, cfg.row_stride};
   assign row2_in  = row_full[AW-1:0];

   always_comb begin
      we2_in = (cov1_ff != '0) && cfg.box_ok &&
               (tx_ext >= cfg.x0) && (tx_ext < cfg.x1) &&
               (ty_ext >= cfg.y0) && (ty_ext < cfg.y1);
      for (int i = 0; i < NCh; i++) begin
         src2_in[i] = {{ChW{1'b0}}, cfg.text_color[ChW*i +: ChW]} * {{ChW{1'b0}}, cov1_ff};
         dst2_in[i] = {{ChW{1'b0}}, dp1_ff[ChW*i +: ChW]} * {{ChW{1'b0}}, inv_cov};
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         we2_ff  <= we2_in;
         src2_ff <= src2_in;
         dst2_ff <= dst2_in;
         row2_ff <= row2_in;
         tx2_ff  <= tx1_ff;
      end
   end

   // Stage 3: sums and full address (tx is non-negative whenever we is set)
   always_comb begin
      for (int i = 0; i < NCh; i++) begin
         sum3_in[i] = src2_ff[i] + dst2_ff[i];
      end
      addr3_in = row2_ff + {{(AW - CW){1'b0}}, tx2_ff};
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         we3_ff   <= we2_ff;
         sum3_ff  <= sum3_in;
         addr3_ff <= addr3_in;
      end
   end

   // Stage 4: divide by 255, force alpha, zero skipped samples
   always_comb begin
      data4_in = '0;
      if (we3_ff) begin
         data4_in[AW-1:0] = addr3_ff;
         for (int i = 0; i < NCh; i++) begin
            data4_in[AW + ChW*i +: ChW] = cbl_pkg::div255(sum3_ff[i]);
         end
         data4_in[AW + ChW*NCh +: ChW] = cbl_pkg::AlphaOpaque;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         we4_ff   <= we3_ff;
         data4_ff <= data4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_we    = we4_ff;
   assign out_data  = data4_ff;

endmodule

`default_nettype wire

### rtl/core/clipped_coverage_blend_top.sv
// Top level of the clipped coverage blend block.
//
// Blends glyph coverage samples into RGB888 destination pixels.
// req channel: one coverage sample per transfer (x, y, coverage, current pixel).
// rsp channel: one result per sample: write flag on tuser, then address and
// blended pixel on tdata. Skipped samples come out with a zero payload.
// csr port: eight registers at byte addresses 0x00..0x1C (color, buffer size,
// row stride, clip box). Write them only while no samples are in flight.
// Path: each sample passes the capture, product, sum and output registers
// before rsp_tvalid rises. Throughput: one sample per cycle, sustained while
// rsp_tready is high; the pipeline is four register stages (capture, clip
// test and 8x8 / 16x14 multiplies, sums, divide by 255).
// Stalls: when rsp_tready is low, empty stages still fill, so req_tready stays
// high until all four stages hold a sample; nothing is dropped or repeated.
// Reset: synchronous; clears the configuration registers to zero and empties the pipeline.
`default_nettype none

module clipped_coverage_blend_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Sample input
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: target_x[15:0], target_y[31:16], coverage[39:32], dest_pixel[71:40]
   input  wire logic [cbl_pkg::ReqDataWidth-1:0]   req_tdata,
   // Result output
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: pixel_address[25:0], new_pixel[57:26], zero[63:58]
   output logic      [cbl_pkg::RspDataWidth-1:0]   rsp_tdata,
   // tuser: write_enable[0]
   output logic                                    rsp_tuser,
   // Register access
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cbl_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [cbl_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic      [cbl_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                    csr_pready
);

   cbl_pkg::cbl_cfg_type                cfg;
   logic [cbl_pkg::RspBodyWidth-1:0]    body;

   // Configuration registers
   cbl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Blend pipeline
   cbl_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_we    (rsp_tuser),
      .out_data  (body)
   );

   assign rsp_tdata = {{(cbl_pkg::RspDataWidth - cbl_pkg::RspBodyWidth){1'b0}}, body};

   // Skipped samples carry a zero payload
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("skipped sample with nonzero payload");

   // Written pixels are opaque
   a_alpha_opaque: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[cbl_pkg::RspBodyWidth-1 -: cbl_pkg::ChanWidth] == cbl_pkg::AlphaOpaque))
      else $error("written pixel alpha is not opaque");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result stays valid while req_tready is high
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && req_tready) |=> rsp_tvalid)
      else $error("pipeline lost a stalled result");

endmodule

`default_nettype wire

### tb/sv/cbl_blend_checker.sv
// Checker for the clipped coverage blend block: register shadow, result predictor, compare.
`default_nettype none

module cbl_blend_checker
   import cbl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   // tdata: target_x[15:0], target_y[31:16], coverage[39:32], dest_pixel[71:40]
   input  wire logic [ReqDataWidth-1:0]   req_tdata,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // tdata: pixel_address[25:0], new_pixel[57:26], zero[63:58]
   input  wire logic [RspDataWidth-1:0]   rsp_tdata,
   // tuser: write_enable[0]
   input  wire logic                      rsp_tuser,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [CsrDataWidth-1:0]   csr_pwdata,
   input  wire logic                      csr_pready,
   output int                             failures,
   output int                             pending
);

   typedef struct packed {
      logic                  write_enable;
      logic [AddrWidth-1:0]  pixel_address;
      logic [PixelWidth-1:0] new_pixel;
   } blend_result_t;

   // Shadow copy of the register file
   logic [ColorWidth-1:0]        text_color;
   logic [DimWidth-1:0]          buffer_width;
   logic [DimWidth-1:0]          buffer_height;
   logic [DimWidth-1:0]          row_stride;
   logic signed [CoordWidth-1:0] clip_left;
   logic signed [CoordWidth-1:0] clip_top;
   logic signed [CoordWidth-1:0] clip_right;
   logic signed [CoordWidth-1:0] clip_bottom;

   blend_result_t expected_pixels[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   // (src*a + dst*(255-a)) / 255, truncated
   function automatic logic [ChanWidth-1:0] blend_channel(input int src, input int dst,
                                                          input int a);
      int mixed;
      mixed = (src * a + dst * (255 - a)) / 255;
      return mixed[ChanWidth-1:0];
   endfunction

   function automatic blend_result_t predict_blend(input logic [ReqDataWidth-1:0] sample);
      int                    tx, ty, a;
      int                    x0, y0, x1, y1;
      int                    bw, bh;
      logic [PixelWidth-1:0] dest;
      longint                full;
      blend_result_t         res;
      tx   = $signed(sample[15:0]);
      ty   = $signed(sample[31:16]);
      a    = sample[39:32];
      dest = sample[71:40];
      bw   = buffer_width;
      bh   = buffer_height;
      // clip box cut to the buffer
      x0 = (clip_left < 0) ? 0 : clip_left;
      y0 = (clip_top < 0) ? 0 : clip_top;
      x1 = (clip_right > bw) ? bw : clip_right;
      y1 = (clip_bottom > bh) ? bh : clip_bottom;
      res = '0;
      if (a != 0 && x1 > x0 && y1 > y0 && tx >= x0 && tx < x1 && ty >= y0 && ty < y1) begin
         // coordinates are non-negative here; address wraps at 26 bits
         full = longint'(ty) * longint'(row_stride) + longint'(tx);
         res.write_enable  = 1'b1;
         res.pixel_address = full[AddrWidth-1:0];
         res.new_pixel = {AlphaOpaque,
                          blend_channel(text_color[23:16], dest[23:16], a),
                          blend_channel(text_color[15:8], dest[15:8], a),
                          blend_channel(text_color[7:0], dest[7:0], a)};
      end
      return res;
   endfunction

   always @(posedge clock) begin
      blend_result_t want;
      blend_result_t got;
      if (reset) begin
         text_color    = '0;
         buffer_width  = '0;
         buffer_height = '0;
         row_stride    = '0;
         clip_left     = '0;
         clip_top      = '0;
         clip_right    = '0;
         clip_bottom   = '0;
         expected_pixels.delete();
      end else begin
         // register write transfer
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (cbl_reg_type'(csr_paddr[4:2]))
               REG_TEXT_COLOR:    text_color    = csr_pwdata[ColorWidth-1:0];
               REG_BUFFER_WIDTH:  buffer_width  = csr_pwdata[DimWidth-1:0];
               REG_BUFFER_HEIGHT: buffer_height = csr_pwdata[DimWidth-1:0];
               REG_ROW_STRIDE:    row_stride    = csr_pwdata[DimWidth-1:0];
               REG_CLIP_LEFT:     clip_left     = csr_pwdata[CoordWidth-1:0];
               REG_CLIP_TOP:      clip_top      = csr_pwdata[CoordWidth-1:0];
               REG_CLIP_RIGHT:    clip_right    = csr_pwdata[CoordWidth-1:0];
               REG_CLIP_BOTTOM:   clip_bottom   = csr_pwdata[CoordWidth-1:0];
               default: ;
            endcase
         end
         // sample transfer: queue its expected pixel write
         if (req_tvalid && req_tready)
            expected_pixels.push_back(predict_blend(req_tdata));
         // result transfer: compare against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got.write_enable  = rsp_tuser;
            got.pixel_address = rsp_tdata[AddrWidth-1:0];
            got.new_pixel     = rsp_tdata[AddrWidth +: PixelWidth];
            if (expected_pixels.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result: we=%0b addr=%h pixel=%h",
                           got.write_enable, got.pixel_address, got.new_pixel);
            end else begin
               want = expected_pixels.pop_front();
               if (got != want) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch: expected we=%0b addr=%h pixel=%h, got we=%0b addr=%h pixel=%h",
                              want.write_enable, want.pixel_address, want.new_pixel,
                              got.write_enable, got.pixel_address, got.new_pixel);
               end
            end
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Top of the clipped coverage blend testbench: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
   import cbl_pkg::*;

   localparam int CycleLimit = 200000;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_tvalid    = 1'b0;
   wire logic               req_tready;
   logic [ReqDataWidth-1:0] req_tdata     = '0;
   wire logic               rsp_tvalid;
   logic                    rsp_tready    = 1'b1;
   wire logic [RspDataWidth-1:0] rsp_tdata;
   wire logic               rsp_tuser;
   logic                    csr_psel      = 1'b0;
   logic                    csr_penable   = 1'b0;
   logic                    csr_pwrite    = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr     = '0;
   logic [CsrDataWidth-1:0] csr_pwdata    = '0;
   wire logic [CsrDataWidth-1:0] csr_prdata;
   wire logic               csr_pready;

   int failures;
   int pending;
   int cycles     = 0;
   int stall_left = 0;
   bit calm       = 1'b0;

   // box the current setting actually allows, used to aim the samples
   int aim_x0, aim_x1, aim_y0, aim_y1;

   clipped_coverage_blend_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cbl_blend_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // result side backpressure: random bursts with rsp_tready low
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one register write: setup, access until csr_pready, then idle
   task automatic write_reg(input cbl_reg_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, wait until every queued sample has come back, then settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] color, input logic [31:0] bw,
                                input logic [31:0] bh, input logic [31:0] stride,
                                input logic [31:0] left, input logic [31:0] top,
                                input logic [31:0] right, input logic [31:0] bottom);
      int w, h, l, t, r, b;
      drain();
      write_reg(REG_TEXT_COLOR, color);
      write_reg(REG_BUFFER_WIDTH, bw);
      write_reg(REG_BUFFER_HEIGHT, bh);
      write_reg(REG_ROW_STRIDE, stride);
      write_reg(REG_CLIP_LEFT, left);
      write_reg(REG_CLIP_TOP, top);
      write_reg(REG_CLIP_RIGHT, right);
      write_reg(REG_CLIP_BOTTOM, bottom);
      w = bw[DimWidth-1:0];
      h = bh[DimWidth-1:0];
      l = $signed(left[15:0]);
      t = $signed(top[15:0]);
      r = $signed(right[15:0]);
      b = $signed(bottom[15:0]);
      aim_x0 = (l < 0) ? 0 : l;
      aim_y0 = (t < 0) ? 0 : t;
      aim_x1 = (r > w) ? w : r;
      aim_y1 = (b > h) ? h : b;
   endtask

   // one sample transfer, with an occasional idle burst ahead of it
   task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] cov, input logic [31:0] dest);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dest, cov, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // coordinate mostly near or inside [lo, hi), sometimes on an edge, sometimes anywhere
   function automatic logic [15:0] aim_coord(input int lo, input int hi);
      int span;
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      span = (hi > lo) ? hi - lo + 3 : 4;
      case (pick)
         0:       v = $urandom;
         1:       v = lo - 1;
         2:       v = lo;
         3:       v = hi - 1;
         4:       v = hi;
         default: v = lo - 2 + int'($urandom_range(0, span));
      endcase
      return v[15:0];
   endfunction

   task automatic random_sample();
      logic [7:0] cov;
      int         pick;
      pick = $urandom_range(0, 9);
      cov  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      send_sample(aim_coord(aim_x0, aim_x1), aim_coord(aim_y0, aim_y1), cov, $urandom);
   endtask

   task automatic random_setting();
      int w, h, l, t;
      if ($urandom_range(0, 3) == 0) begin
         // anything the register widths allow, including out-of-range sizes
         apply_setting($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
      end else begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16383) : $urandom_range(1, 400);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16383) : $urandom_range(1, 300);
         l = int'($urandom_range(0, w + 16)) - 16;
         t = int'($urandom_range(0, h + 16)) - 16;
         apply_setting($urandom_range(0, 24'hffffff), w, h,
                       w + $urandom_range(0, 64),
                       l, t,
                       l + int'($urandom_range(0, w + 16)),
                       t + int'($urandom_range(0, h + 16)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: empty box, nothing written
      send_sample(16'd0, 16'd0, 8'd255, 32'h00ffffff);
      send_sample(16'd1, 16'd1, 8'd128, 32'h12345678);
      send_sample(16'h8000, 16'h7fff, 8'd1, 32'hffffffff);

      // small buffer, clip box wider than the buffer
      apply_setting(32'h00ff8040, 64, 32, 80, -10, -10, 100, 100);
      send_sample(16'd0, 16'd0, 8'd255, 32'h00000000);
      send_sample(16'd63, 16'd31, 8'd255, 32'hffffffff);
      send_sample(16'd64, 16'd0, 8'd255, 32'h00000000);
      send_sample(16'hffff, 16'd0, 8'd255, 32'h00000000);
      send_sample(16'd0, 16'd32, 8'd200, 32'h00000000);
      send_sample(16'd10, 16'd10, 8'd0, 32'h00abcdef);
      send_sample(16'd10, 16'd10, 8'd1, 32'hffffffff);
      send_sample(16'd10, 16'd11, 8'd128, 32'h12345678);
      send_sample(16'd5, 16'd5, 8'd254, 32'h80808080);
      send_sample(16'h8000, 16'h8000, 8'd255, 32'h00000000);
      send_sample(16'h7fff, 16'h7fff, 8'd255, 32'h00000000);

      // extremes: oversized buffer and stride, widest clip box, address wraps
      apply_setting(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'h00008000, 32'h00008000, 32'h00007fff, 32'h00007fff);
      send_sample(16'd16382, 16'd16382, 8'd255, 32'h00000000);
      send_sample(16'd0, 16'd0, 8'd1, 32'hffffffff);
      send_sample(16'd16383, 16'd0, 8'd255, 32'h00000000);
      send_sample(16'd8000, 16'd4097, 8'd77, 32'h5a5aa5a5);

      // empty box: right edge equal to left edge
      apply_setting(32'h00000000, 100, 100, 100, 20, 0, 20, 50);
      send_sample(16'd20, 16'd10, 8'd255, 32'h00000000);
      send_sample(16'd19, 16'd10, 8'd255, 32'h00000000);
      // empty box: left edge beyond the buffer width
      apply_setting(32'h00123456, 40, 40, 40, 50, 0, 200, 30);
      send_sample(16'd45, 16'd5, 8'd255, 32'h00000000);

      // random settings, the last one with no idling on either side
      for (int phase = 0; phase < 6; phase++) begin
         random_setting();
         if (phase == 5) calm = 1'b1;
         repeat (100) random_sample();
      end
      req_tvalid <= 1'b0;

      drain();
      if (failures == 0 && pending == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
rtl/core/cbl_pkg.sv
rtl/core/cbl_csr.sv
rtl/core/cbl_pipe.sv
rtl/core/clipped_coverage_blend_top.sv
tb/sv/cbl_blend_checker.sv
tb/sv/tb_top.sv
